### src/fgpd_pkg.sv
// Shared types, constants and lookup tables for the fuzzy-gain PD steering block.
// No dependencies; every other file imports this package.
package fgpd_pkg;

	// Field widths
	localparam int RAW_W   = 8;
	localparam int DUTY_W  = 15;
	localparam int GAIN_W  = 6;
	localparam int DGAIN_W = 5;
	localparam int DBAND_W = 7;
	localparam int IDX_W   = 3;

	// Serial divider sizing
	localparam int DIV_NUM_W = 15;
	localparam int DIV_DEN_W = 9;
	localparam int DIV_QUO_W = 10;
	localparam int DIV_CNT_W = 4;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_CENTER = 3'd0;
	localparam logic [IDX_W-1:0] REG_MIN    = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX    = 3'd2;
	localparam logic [IDX_W-1:0] REG_DGAIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DBAND  = 3'd4;

	// Reset values
	localparam logic [DUTY_W-1:0]  CENTER_RST = 15'd1500;
	localparam logic [DUTY_W-1:0]  MIN_RST    = 15'd1200;
	localparam logic [DUTY_W-1:0]  MAX_RST    = 15'd1800;
	localparam logic [DGAIN_W-1:0] DGAIN_RST  = 5'd6;
	localparam logic [DBAND_W-1:0] DBAND_RST  = 7'd1;
	localparam logic [GAIN_W-1:0]  GAIN_RST   = 6'd30;
	localparam logic [GAIN_W-1:0]  GAIN_MAX   = 6'd55;

	// Membership percentage full scale
	localparam logic [6:0] PCT_FULL = 7'd100;

	// Divider pass settings: quotient bits per pass and constant divisors
	localparam logic [DIV_CNT_W-1:0] FILT_STEPS  = 4'd8;
	localparam logic [DIV_CNT_W-1:0] MEM_STEPS   = 4'd7;
	localparam logic [DIV_CNT_W-1:0] GAIN_STEPS  = 4'd6;
	localparam logic [DIV_CNT_W-1:0] PTERM_STEPS = 4'd10;
	localparam logic [DIV_DEN_W-1:0] DEN_FILT    = 9'd100;
	localparam logic [DIV_DEN_W-1:0] DEN_PTERM   = 9'd10;

	// Breakpoints, output levels and rule table
	localparam logic signed [7:0] ERR_BP [7] = '{-8'sd71, -8'sd50, -8'sd25, 8'sd0,
		8'sd22, 8'sd49, 8'sd70};
	localparam logic signed [7:0] CHG_BP [5] = '{-8'sd15, -8'sd8, 8'sd0, 8'sd8, 8'sd15};
	localparam logic [5:0] LEVEL_TENTHS [7] = '{6'd6, 6'd16, 6'd27, 6'd36, 6'd44,
		6'd49, 6'd55};
	localparam logic [2:0] RULE_TAB [7][5] = '{
		'{3'd6, 3'd5, 3'd5, 3'd3, 3'd3},
		'{3'd5, 3'd4, 3'd3, 3'd2, 3'd2},
		'{3'd4, 3'd2, 3'd1, 3'd1, 3'd1},
		'{3'd2, 3'd1, 3'd0, 3'd1, 3'd2},
		'{3'd1, 3'd1, 3'd1, 3'd2, 3'd4},
		'{3'd2, 3'd2, 3'd3, 3'd4, 3'd5},
		'{3'd3, 3'd3, 3'd5, 3'd5, 3'd6}
	};

	// Segment lookup result: segment, clamp flags, distance to upper breakpoint, width
	typedef struct packed {
		logic [2:0] seg;
		logic       lo;
		logic       hi;
		logic [4:0] off;
		logic [4:0] wid;
	} fz_seg_t;

	typedef struct packed {
		logic [2:0] un;
		logic [6:0] w;
	} rule_term_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_QUO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FILT, S_WFILT, S_EMEM, S_WEMEM, S_DMEM, S_WDMEM, S_RULE, S_ACC,
		S_GAIN, S_WGAIN, S_PROD, S_PTERM, S_WPTERM, S_DTERM, S_DUTY, S_OUT
	} fgpd_state_t;

	// Error segment lookup; clamped below the first and above the last breakpoint
	function automatic fz_seg_t seg_err(input logic signed [7:0] v);
		fz_seg_t r;
		r = '0;
		if (v <= ERR_BP[0]) begin
			r.lo  = 1'b1;
			r.wid = 5'(ERR_BP[1] - ERR_BP[0]);
		end else if (v >= ERR_BP[6]) begin
			r.seg = 3'd5;
			r.hi  = 1'b1;
			r.wid = 5'(ERR_BP[6] - ERR_BP[5]);
		end else begin
			for (int i = 5; i >= 0; i--) begin
				if (v <= ERR_BP[i+1])
					r.seg = 3'(i);
			end
			r.off = 5'(ERR_BP[r.seg + 3'd1] - v);
			r.wid = 5'(ERR_BP[r.seg + 3'd1] - ERR_BP[r.seg]);
		end
		return r;
	endfunction

	// Change segment lookup, same scheme on the shorter table
	function automatic fz_seg_t seg_chg(input logic signed [8:0] v);
		fz_seg_t r;
		r = '0;
		if (v <= 9'(CHG_BP[0])) begin
			r.lo  = 1'b1;
			r.wid = 5'(CHG_BP[1] - CHG_BP[0]);
		end else if (v >= 9'(CHG_BP[4])) begin
			r.seg = 3'd3;
			r.hi  = 1'b1;
			r.wid = 5'(CHG_BP[4] - CHG_BP[3]);
		end else begin
			for (int i = 3; i >= 0; i--) begin
				if (v <= 9'(CHG_BP[i+1]))
					r.seg = 3'(i);
			end
			r.off = 5'(9'(CHG_BP[r.seg + 3'd1]) - v);
			r.wid = 5'(CHG_BP[r.seg + 3'd1] - CHG_BP[r.seg]);
		end
		return r;
	endfunction

endpackage

### src/fgpd_if.sv
// Valid/ready channel interfaces for the steering error word and the result word.
// Depends on fgpd_pkg for field widths.
interface fgpd_in_if import fgpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RAW_W-1:0] raw_error;

	modport source (output valid, output raw_error, input ready);
	modport sink (input valid, input raw_error, output ready);
endinterface

interface fgpd_out_if import fgpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [DUTY_W-1:0]       duty;
	logic [GAIN_W-1:0]       gain_tenths;
	logic signed [RAW_W-1:0] filtered_error;

	modport source (output valid, output duty, output gain_tenths, output filtered_error,
		input ready);
	modport sink (input valid, input duty, input gain_tenths, input filtered_error,
		output ready);
endinterface

### src/fgpd_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by all passes.
// Depends on fgpd_pkg for the request/response structs.
module fgpd_sdiv import fgpd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;
	logic [DIV_CNT_W-1:0] lsh;

	// Trial subtract of the partial remainder with the next numerator bit
	always_comb begin
		trial = {rem_q, num_q[DIV_NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		lsh   = DIV_CNT_W'(DIV_NUM_W) - req.steps;
	end

	// Step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift registers: numerator bits out, quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= DIV_DEN_W'(req.num >> req.steps);
			num_q <= req.num << lsh;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QUO_W-2:0], fits};
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quo: quo_q};

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q) else $error("partial remainder not below divisor");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("divider stopped without done");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held longer than one cycle");
`endif

endmodule

### src/fgpd_rules.sv
// Rule evaluation: four table cells, min-weights, and duplicate-rule pruning.
// Depends on fgpd_pkg for the rule table and rule_term_t.
module fgpd_rules import fgpd_pkg::*; (
	input  logic [2:0]             es,
	input  logic [2:0]             ds,
	input  logic [6:0]             e_low,
	input  logic [6:0]             d_low,
	output rule_term_t [3:0]       terms
);

	function automatic logic [6:0] min7(input logic [6:0] a, input logic [6:0] b);
		return (a < b) ? a : b;
	endfunction

	logic [6:0] e_high;
	logic [6:0] d_high;
	logic [2:0] es1;
	logic [2:0] ds1;
	logic [2:0] un [4];
	logic [6:0] w  [4];

	always_comb begin
		e_high = PCT_FULL - e_low;
		d_high = PCT_FULL - d_low;
		es1    = es + 3'd1;
		ds1    = ds + 3'd1;

		// Corner cells of the active segment pair
		un[0] = RULE_TAB[es][ds];
		un[1] = RULE_TAB[es1][ds];
		un[2] = RULE_TAB[es][ds1];
		un[3] = RULE_TAB[es1][ds1];

		w[0] = min7(e_low, d_low);
		w[1] = min7(e_high, d_low);
		w[2] = min7(e_low, d_high);
		w[3] = min7(e_high, d_high);

		// Equal rules: keep the larger weight, a tie clears the earlier one
		for (int a = 0; a < 3; a++) begin
			for (int b = a + 1; b < 4; b++) begin
				if (un[a] == un[b]) begin
					if (w[a] > w[b])
						w[b] = '0;
					else
						w[a] = '0;
				end
			end
		end

		for (int k = 0; k < 4; k++)
			terms[k] = '{un: un[k], w: w[k]};
	end

endmodule

### src/fuzzy_gain_pd_steering_core.sv
// Top level of the fuzzy self-tuning PD steering block.
// Depends on fgpd_pkg, fgpd_if, fgpd_sdiv and fgpd_rules.
//
// Usage:
//   err_ch carries one signed steering error per word; res_ch returns one word
//   per input with the clamped duty, the gain in tenths and the filtered error.
//   The write port (wr_en, wr_index, wr_data) sets center, min and max duty,
//   derivative gain and dead band; write it only while no word is in flight.
//   Words are processed one at a time. A result is loaded into the output
//   register after its word has run through the whole sequence; when the rule
//   weights sum to zero the gain average pass is skipped and the gain is kept.
//   The block is ready to take the next word in the cycle after the load.
//   The time per word is set by the single bit-serial divider, which runs up
//   to five passes per word (filter, two memberships, gain average, P term),
//   one quotient bit per cycle.
//   A new word is accepted while the previous result still waits in the output
//   register; if the receiver stalls longer, the block holds its finished
//   result internally and does not accept again until the register frees.
//   Reset clears the filter history to zero, the gain to 3.0 and the registers
//   to their defaults; no result is pending after reset.
module fuzzy_gain_pd_steering_core import fgpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [DUTY_W-1:0] wr_data,
	fgpd_in_if.sink          err_ch,
	fgpd_out_if.source       res_ch
);

	fgpd_state_t state_q, state_nxt;

	// Configuration
	logic [DUTY_W-1:0]  center_q, min_q, max_q;
	logic [DGAIN_W-1:0] dgain_q;
	logic [DBAND_W-1:0] dband_q;

	// Persistent state
	logic signed [RAW_W-1:0] prev_q;
	logic [GAIN_W-1:0]       gain_q;

	// Working registers
	logic signed [RAW_W-1:0] raw_q;
	logic signed [RAW_W-1:0] filt_q;
	logic signed [8:0]       diff_q;
	logic [6:0]              e0_q, d0_q;
	rule_term_t [3:0]        terms_q;
	logic [1:0]              k_q;
	logic [14:0]             acc_q;
	logic [8:0]              wsum_q;
	logic [12:0]             prod_q;
	logic signed [10:0]      p_q;
	logic signed [13:0]      dterm_q;
	logic signed [17:0]      duty_q;

	// Output register
	logic                    out_valid_q;
	logic [DUTY_W-1:0]       duty_out_q;
	logic [GAIN_W-1:0]       gain_out_q;
	logic signed [RAW_W-1:0] filt_out_q;

	// Combinational
	logic                    in_rdy;
	logic                    accept;
	logic                    out_free;
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	logic signed [14:0]      mix;
	logic [14:0]             mix_mag;
	logic [7:0]              q8;
	logic signed [RAW_W-1:0] filt_c;
	logic signed [8:0]       diff_c;
	fz_seg_t                 seg_e, seg_d;
	logic [6:0]              e_low_c, d_low_c;
	rule_term_t [3:0]        terms_c;
	logic [12:0]             term_prod;
	logic [7:0]              fmag;
	logic                    in_band;
	logic signed [17:0]      duty_hi, duty_cl;

	fgpd_sdiv u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fgpd_rules u_rules (
		.es    (seg_e.seg),
		.ds    (seg_d.seg),
		.e_low (e0_q),
		.d_low (d0_q),
		.terms (terms_c)
	);

	// Datapath helpers
	always_comb begin
		accept   = err_ch.valid && in_rdy;
		out_free = !out_valid_q || res_ch.ready;

		// Low-pass numerator and its magnitude for the divide by 100
		mix     = 15'sd88 * 15'(raw_q) + 15'sd12 * 15'(prev_q);
		mix_mag = mix[14] ? 15'(-mix) : 15'(mix);
		q8      = div_rsp.quo[7:0];
		filt_c  = mix[14] ? 8'(-q8) : q8;
		diff_c  = 9'(filt_c) - 9'(prev_q);

		seg_e   = seg_err(filt_q);
		seg_d   = seg_chg(diff_q);
		e_low_c = seg_e.lo ? PCT_FULL : (seg_e.hi ? 7'd0 : div_rsp.quo[6:0]);
		d_low_c = seg_d.lo ? PCT_FULL : (seg_d.hi ? 7'd0 : div_rsp.quo[6:0]);

		term_prod = 13'(terms_q[k_q].w) * 13'(LEVEL_TENTHS[terms_q[k_q].un]);

		fmag    = filt_q[7] ? 8'(-filt_q) : 8'(filt_q);
		in_band = fmag < {1'b0, dband_q};

		// Clamp: max first, then min wins
		duty_hi = (duty_q > signed'(18'(max_q))) ? signed'(18'(max_q)) : duty_q;
		duty_cl = (duty_hi < signed'(18'(min_q))) ? signed'(18'(min_q)) : duty_hi;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:   if (err_ch.valid) state_nxt = S_FILT;
			S_FILT:   state_nxt = S_WFILT;
			S_WFILT:  if (div_rsp.done) state_nxt = S_EMEM;
			S_EMEM:   state_nxt = S_WEMEM;
			S_WEMEM:  if (div_rsp.done) state_nxt = S_DMEM;
			S_DMEM:   state_nxt = S_WDMEM;
			S_WDMEM:  if (div_rsp.done) state_nxt = S_RULE;
			S_RULE:   state_nxt = S_ACC;
			S_ACC:    if (k_q == 2'd3) state_nxt = S_GAIN;
			S_GAIN:   state_nxt = (wsum_q != '0) ? S_WGAIN : S_PROD;
			S_WGAIN:  if (div_rsp.done) state_nxt = S_PROD;
			S_PROD:   state_nxt = S_PTERM;
			S_PTERM:  state_nxt = S_WPTERM;
			S_WPTERM: if (div_rsp.done) state_nxt = S_DTERM;
			S_DTERM:  state_nxt = S_DUTY;
			S_DUTY:   state_nxt = S_OUT;
			S_OUT:    if (out_free) state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	// State outputs: input ready and divider requests
	always_comb begin
		in_rdy  = 1'b0;
		div_req = '0;
		unique case (state_q)
			S_IDLE:  in_rdy = 1'b1;
			S_FILT:  div_req = '{start: 1'b1, steps: FILT_STEPS, num: mix_mag,
				den: DEN_FILT};
			S_EMEM:  div_req = '{start: 1'b1, steps: MEM_STEPS,
				num: 15'(seg_e.off) * 15'(PCT_FULL), den: 9'(seg_e.wid)};
			S_DMEM:  div_req = '{start: 1'b1, steps: MEM_STEPS,
				num: 15'(seg_d.off) * 15'(PCT_FULL), den: 9'(seg_d.wid)};
			S_GAIN:  div_req = '{start: (wsum_q != '0), steps: GAIN_STEPS, num: acc_q,
				den: wsum_q};
			S_PTERM: div_req = '{start: 1'b1, steps: PTERM_STEPS, num: 15'(prod_q),
				den: DEN_PTERM};
			default: ;
		endcase
	end

	assign err_ch.ready = in_rdy;

	// Control state, configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			center_q    <= CENTER_RST;
			min_q       <= MIN_RST;
			max_q       <= MAX_RST;
			dgain_q     <= DGAIN_RST;
			dband_q     <= DBAND_RST;
			prev_q      <= '0;
			gain_q      <= GAIN_RST;
		end else begin
			state_q <= state_nxt;

			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (res_ch.ready)
				out_valid_q <= 1'b0;

			if (state_q == S_RULE)
				k_q <= '0;
			else if (state_q == S_ACC)
				k_q <= k_q + 2'd1;

			if (state_q == S_WFILT && div_rsp.done)
				prev_q <= filt_c;
			if (state_q == S_WGAIN && div_rsp.done)
				gain_q <= div_rsp.quo[GAIN_W-1:0];

			if (wr_en) begin
				unique case (wr_index)
					REG_CENTER: center_q <= wr_data;
					REG_MIN:    min_q    <= wr_data;
					REG_MAX:    max_q    <= wr_data;
					REG_DGAIN:  dgain_q  <= wr_data[DGAIN_W-1:0];
					REG_DBAND:  dband_q  <= wr_data[DBAND_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Working registers along the sequence
	always_ff @(posedge clk) begin
		if (accept)
			raw_q <= err_ch.raw_error;
		if (state_q == S_WFILT && div_rsp.done) begin
			filt_q <= filt_c;
			diff_q <= diff_c;
		end
		if (state_q == S_WEMEM && div_rsp.done)
			e0_q <= e_low_c;
		if (state_q == S_WDMEM && div_rsp.done)
			d0_q <= d_low_c;
		if (state_q == S_RULE) begin
			terms_q <= terms_c;
			acc_q   <= '0;
			wsum_q  <= '0;
		end
		if (state_q == S_ACC) begin
			acc_q  <= acc_q + 15'(term_prod);
			wsum_q <= wsum_q + 9'(terms_q[k_q].w);
		end
		if (state_q == S_PROD)
			prod_q <= 13'(gain_q) * 13'(fmag);
		if (state_q == S_WPTERM && div_rsp.done)
			p_q <= filt_q[7] ? -11'(div_rsp.quo) : 11'(div_rsp.quo);
		if (state_q == S_DTERM)
			dterm_q <= 14'(signed'({1'b0, dgain_q})) * 14'(diff_q);
		if (state_q == S_DUTY)
			duty_q <= in_band ? signed'(18'(center_q))
				: signed'(18'(center_q)) - 18'(p_q) - 18'(dterm_q);
		if (state_q == S_OUT && out_free) begin
			duty_out_q <= duty_cl[DUTY_W-1:0];
			gain_out_q <= gain_q;
			filt_out_q <= filt_q;
		end
	end

	assign res_ch.valid          = out_valid_q;
	assign res_ch.duty           = duty_out_q;
	assign res_ch.gain_tenths    = gain_out_q;
	assign res_ch.filtered_error = filt_out_q;

`ifndef SYNTHESIS
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= GAIN_MAX) else $error("gain above top output level");
	a_duty_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && (min_q <= max_q)) |->
		(duty_out_q >= min_q && duty_out_q <= max_q))
		else $error("duty outside configured limits");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WFILT || state_q == S_WEMEM ||
		state_q == S_WDMEM || state_q == S_WGAIN || state_q == S_WPTERM))
		else $error("divider result arrived outside a wait state");
`endif

endmodule

### test/tb_fuzzy_gain_pd_steering_core.sv
`timescale 1ns / 100ps
// Self-checking bench for fuzzy_gain_pd_steering_core: a scoreboard class predicts each
// result word from the accepted steering error. Depends on fgpd_pkg, fgpd_if and the RTL.
module tb_fuzzy_gain_pd_steering_core;
	import fgpd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_LEN    = 400;
	localparam int SETTLE      = 100;
	localparam int PHASE_WORDS = 178;
	localparam int PHASES      = 8;

	// Write to an index the block does not decode
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	// Fuzzy tables: error and change breakpoints, gain levels, rule cells row by row
	localparam int ERR_KNEE [7] = '{-71, -50, -25, 0, 22, 49, 70};
	localparam int CHG_KNEE [5] = '{-15, -8, 0, 8, 15};
	localparam int GAIN_LEVEL [7] = '{6, 16, 27, 36, 44, 49, 55};
	localparam int RULE_CELL [35] = '{
		6, 5, 5, 3, 3,
		5, 4, 3, 2, 2,
		4, 2, 1, 1, 1,
		2, 1, 0, 1, 2,
		1, 1, 1, 2, 4,
		2, 2, 3, 4, 5,
		3, 3, 5, 5, 6
	};

	// Directed errors: full-scale swings, clamps past both table ends, breakpoints
	localparam int DIRECTED [25] = '{0, 127, 127, 127, -128, -128, -128, 127, 0, 1, -1,
		2, -2, 22, 49, 70, 80, -25, -50, -71, -80, 8, -8, 60, -128};

	typedef struct packed {
		logic [DUTY_W-1:0]       duty;
		logic [GAIN_W-1:0]       gain;
		logic signed [RAW_W-1:0] filt;
	} steer_word_t;

	// Steering predictor with its own register copy and filter/gain history
	class steer_board;
		int center, duty_lo, duty_hi, d_gain, band;
		int last_filt;
		int gain_state;
		int errors;
		steer_word_t due_q[$];

		function new();
			center     = 1500;
			duty_lo    = 1200;
			duty_hi    = 1800;
			d_gain     = 6;
			band       = 1;
			last_filt  = 0;
			gain_state = 30;
			errors     = 0;
		endfunction

		function void set_reg(input logic [IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
			case (idx)
				REG_CENTER: center  = int'(data);
				REG_MIN:    duty_lo = int'(data);
				REG_MAX:    duty_hi = int'(data);
				REG_DGAIN:  d_gain  = int'(data[DGAIN_W-1:0]);
				REG_DBAND:  band    = int'(data[DBAND_W-1:0]);
				default: ;
			endcase
		endfunction

		function int lesser(input int x, input int y);
			return (x < y) ? x : y;
		endfunction

		// Segment and lower membership in percent, clamped at both table ends
		function void grade(input int v, input bit on_chg, output int seg, output int low);
			int knee[7];
			int n;
			int i;
			if (on_chg) begin
				n = 5;
				for (i = 0; i < 5; i++)
					knee[i] = CHG_KNEE[i];
			end else begin
				n = 7;
				for (i = 0; i < 7; i++)
					knee[i] = ERR_KNEE[i];
			end
			if (v <= knee[0]) begin
				seg = 0;
				low = 100;
			end else if (v >= knee[n-1]) begin
				seg = n - 2;
				low = 0;
			end else begin
				seg = 0;
				while (v > knee[seg+1])
					seg++;
				low = (100 * (knee[seg+1] - v)) / (knee[seg+1] - knee[seg]);
			end
		endfunction

		// Filter, fuzzy gain update and clamped PD duty for one accepted error word
		function void note_word(input logic signed [RAW_W-1:0] raw);
			int filt, chg, es, ds, e_lo, d_lo, wsum, acc, mag, duty, a, b;
			int rule_of[4];
			int w[4];
			steer_word_t r;
			filt = (88 * int'(raw) + 12 * last_filt) / 100;
			chg = filt - last_filt;
			last_filt = filt;
			grade(filt, 1'b0, es, e_lo);
			grade(chg, 1'b1, ds, d_lo);

			rule_of[0] = RULE_CELL[es * 5 + ds];
			rule_of[1] = RULE_CELL[(es + 1) * 5 + ds];
			rule_of[2] = RULE_CELL[es * 5 + ds + 1];
			rule_of[3] = RULE_CELL[(es + 1) * 5 + ds + 1];
			w[0] = lesser(e_lo, d_lo);
			w[1] = lesser(100 - e_lo, d_lo);
			w[2] = lesser(e_lo, 100 - d_lo);
			w[3] = lesser(100 - e_lo, 100 - d_lo);

			// equal rules keep the larger weight; on a tie the first one is dropped
			for (a = 0; a < 3; a++)
				for (b = a + 1; b < 4; b++)
					if (rule_of[a] == rule_of[b]) begin
						if (w[a] > w[b])
							w[b] = 0;
						else
							w[a] = 0;
					end

			wsum = 0;
			acc = 0;
			for (a = 0; a < 4; a++) begin
				wsum += w[a];
				acc += w[a] * GAIN_LEVEL[rule_of[a]];
			end
			if (wsum > 0)
				gain_state = acc / wsum;

			mag = (filt < 0) ? -filt : filt;
			if (mag < band)
				duty = center;
			else
				duty = center - (gain_state * filt) / 10 - d_gain * chg;
			if (duty > duty_hi)
				duty = duty_hi;
			if (duty < duty_lo)
				duty = duty_lo;

			r.duty = DUTY_W'(duty);
			r.gain = GAIN_W'(gain_state);
			r.filt = RAW_W'(filt);
			due_q.push_back(r);
		endfunction

		function void check_word(input logic [DUTY_W-1:0] duty, input logic [GAIN_W-1:0] gain,
			input logic signed [RAW_W-1:0] filt);
			steer_word_t e;
			if (due_q.size() == 0) begin
				$error("result word with nothing expected: duty %0d gain %0d filt %0d",
					duty, gain, $signed(filt));
				errors++;
				return;
			end
			e = due_q.pop_front();
			if (duty !== e.duty) begin
				$error("duty: expected %0d, got %0d", e.duty, duty);
				errors++;
			end
			if (gain !== e.gain) begin
				$error("gain_tenths: expected %0d, got %0d", e.gain, gain);
				errors++;
			end
			if (filt !== e.filt) begin
				$error("filtered_error: expected %0d, got %0d", $signed(e.filt), $signed(filt));
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [DUTY_W-1:0] wr_data;
	bit idling_on;
	bit hold_off;
	int walk_pos;
	int cycle_count = 0;
	steer_board board;

	fgpd_in_if  err_ch ();
	fgpd_out_if res_ch ();

	fuzzy_gain_pd_steering_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.err_ch   (err_ch),
		.res_ch   (res_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fuzzy_gain_pd_steering_core regression: fail");
			$finish;
		end
	end

	// Accepted error words feed the predictor
	always @(posedge clk) begin
		if (arst_n && err_ch.valid && err_ch.ready)
			board.note_word(err_ch.raw_error);
	end

	// Accepted result words are checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_word(res_ch.duty, res_ch.gain_tenths, res_ch.filtered_error);
	end

	// Result receiver: random stall bursts, plus one long hold-off on request
	initial begin : res_drain
		int burst;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_off = 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				burst = $urandom_range(1, 5);
				repeat (burst - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one error word, with an occasional gap before it
	task automatic send_word(input logic signed [RAW_W-1:0] raw);
		int gap;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			err_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		err_ch.valid <= 1'b1;
		err_ch.raw_error <= raw;
		do @(posedge clk); while (!err_ch.ready);
	endtask

	// Stop offering and wait for every predicted word to come back
	task automatic await_idle();
		err_ch.valid <= 1'b0;
		do @(posedge clk); while (board.due_q.size() != 0);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= DUTY_W'(value);
		@(posedge clk);
		board.set_reg(idx, DUTY_W'(value));
	endtask

	task automatic set_regs(input int center, input int lo, input int hi, input int dg,
		input int band);
		write_reg(REG_CENTER, center);
		write_reg(REG_MIN, lo);
		write_reg(REG_MAX, hi);
		write_reg(REG_DGAIN, dg);
		write_reg(REG_SPARE, $urandom_range(0, 32767));
		write_reg(REG_DBAND, band);
		wr_en <= 1'b0;
	endtask

	// Mostly a random walk with small steps, some breakpoint neighborhoods,
	// some full-range jumps and full-scale extremes
	function automatic logic signed [RAW_W-1:0] pick_raw();
		int sel;
		int step;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			step = int'($urandom_range(0, 40)) - 20;
			walk_pos = walk_pos + step;
			if (walk_pos > 127)
				walk_pos = 127;
			if (walk_pos < -128)
				walk_pos = -128;
		end else if (sel < 80) begin
			walk_pos = ERR_KNEE[$urandom_range(0, 6)] + int'($urandom_range(0, 8)) - 4;
		end else if (sel < 95) begin
			walk_pos = int'($urandom_range(0, 255)) - 128;
		end else begin
			walk_pos = ($urandom_range(0, 1) != 0) ? 127 : -128;
		end
		return RAW_W'(walk_pos);
	endfunction

	initial begin : stim
		int p, k, c;
		board = new();
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		err_ch.valid <= 1'b0;
		err_ch.raw_error <= '0;
		idling_on = 1'b1;
		hold_off = 1'b0;
		walk_pos = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed words on reset settings
		for (k = 0; k < 25; k++)
			send_word(RAW_W'(DIRECTED[k]));
		await_idle();

		// random phases, each on its own register setting
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: set_regs(20000, 0, 20000, 31, 0);
				1: set_regs(0, 0, 20000, 0, 127);
				2: set_regs(1500, 1600, 1400, 6, 1);
				6: set_regs($urandom_range(0, 20000), $urandom_range(0, 20000),
					$urandom_range(0, 20000), $urandom_range(0, 31), $urandom_range(0, 127));
				7: set_regs(1500, 1200, 1800, 6, 1);
				default: begin
					c = $urandom_range(1000, 19000);
					set_regs(c, c - int'($urandom_range(0, 1000)), c + int'($urandom_range(0, 1000)),
						$urandom_range(0, 31), $urandom_range(0, 15));
				end
			endcase
			idling_on = (p != 5) && (p != PHASES - 1);
			if (p == 4)
				hold_off = 1'b1;
			repeat (PHASE_WORDS)
				send_word(pick_raw());
			await_idle();
		end

		repeat (SETTLE) @(posedge clk);
		if (board.due_q.size() != 0) begin
			$error("%0d result words never arrived", board.due_q.size());
			board.errors++;
		end
		if (board.errors == 0) begin
			$display("fuzzy_gain_pd_steering_core regression: pass");
		end else begin
			$display("fuzzy_gain_pd_steering_core regression: fail");
		end
		$finish;
	end

endmodule
